/* sv/cdq_pkg.sv */
`default_nettype none
package cdq_pkg;

    localparam int OCC_W = 5;
    localparam int CMD_W = 3;
    localparam int ST_W  = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = 3'd4;
    localparam logic [CMD_W-1:0] CMD_PEEK_REAR  = 3'd5;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    localparam logic [OCC_W-1:0] CAP_RESET = 5'd16;

    // register index in the config space
    localparam logic REG_CAPACITY = 1'b0;

    // registered response sideband; the word itself comes from the store
    typedef struct packed {
        logic              strobe;
        logic              use_mem;
        logic              min_val;
        logic [ST_W-1:0]   status;
        logic [OCC_W-1:0]  occupancy;
    } cdq_rsp_t;

endpackage
`default_nettype wire

/* sv/cdq_ram.sv */
`default_nettype none
module cdq_ram #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DATA_WIDTH-1:0]    wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [DATA_WIDTH-1:0]    q
);
    logic [DATA_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            q <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

/* sv/cdq_ctrl.sv */
`default_nettype none
module cdq_ctrl #(
    parameter int DEPTH = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              accept,
    input  wire logic [cdq_pkg::CMD_W-1:0]         command,
    input  wire logic                              cfg_we,
    input  wire logic [cdq_pkg::OCC_W-1:0]         cfg_data,
    output logic                                   we,
    output logic      [$clog2(DEPTH)-1:0]          waddr,
    output logic                                   re,
    output logic      [$clog2(DEPTH)-1:0]          raddr,
    output logic      [cdq_pkg::OCC_W-1:0]         cap_reg_out,
    output logic      [cdq_pkg::OCC_W-1:0]         cap_act,
    output cdq_pkg::cdq_rsp_t                      rsp
);
    import cdq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int PW = (AW > OCC_W) ? AW : OCC_W;
    localparam int IW = PW + 1;

    logic [AW-1:0]    head_reg, head_next;
    logic [AW-1:0]    tail_reg, tail_next;
    logic [OCC_W-1:0] count_reg, count_next;
    logic [OCC_W-1:0] cap_reg, cap_next;
    cdq_rsp_t         rsp_reg, rsp_next;

    logic [IW-1:0] cap_ext, head_ext, tail_ext, head_up, tail_up;
    logic [IW-1:0] head_dn, tail_dn;
    logic          full, empty;

    // capacity 0 acts as 1, above DEPTH acts as DEPTH
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_act = OCC_W'(1);
        end
        else if (32'(cap_reg) > 32'(DEPTH))
        begin
            cap_act = OCC_W'(DEPTH);
        end
        else
        begin
            cap_act = cap_reg;
        end
    end

    assign cap_ext  = IW'(cap_act);
    assign head_ext = IW'(head_reg);
    assign tail_ext = IW'(tail_reg);
    assign head_up  = (head_ext + IW'(1) >= cap_ext) ? '0 : head_ext + IW'(1);
    assign tail_up  = (tail_ext + IW'(1) >= cap_ext) ? '0 : tail_ext + IW'(1);
    assign head_dn  = (head_ext == '0 || head_ext >= cap_ext) ? cap_ext - IW'(1)
                                                              : head_ext - IW'(1);
    assign tail_dn  = (tail_ext == '0 || tail_ext >= cap_ext) ? cap_ext - IW'(1)
                                                              : tail_ext - IW'(1);
    assign full     = count_reg >= cap_act;
    assign empty    = count_reg == '0;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        cap_next   = cap_reg;
        we         = 1'b0;
        waddr      = '0;
        re         = 1'b0;
        raddr      = head_reg;
        rsp_next   = '0;

        if (cfg_we)
        begin
            cap_next   = cfg_data;
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end
        else if (accept)
        begin
            rsp_next.strobe = 1'b1;
            case (command) inside
                CMD_PUSH_FRONT, CMD_PUSH_REAR:
                begin
                    if (full)
                    begin
                        rsp_next.status = ST_FULL;
                    end
                    else
                    begin
                        we         = 1'b1;
                        count_next = count_reg + OCC_W'(1);
                        if (empty)
                        begin
                            head_next = '0;
                            tail_next = '0;
                            waddr     = '0;
                        end
                        else if (command == CMD_PUSH_FRONT)
                        begin
                            head_next = AW'(head_dn);
                            waddr     = AW'(head_dn);
                        end
                        else
                        begin
                            tail_next = AW'(tail_up);
                            waddr     = AW'(tail_up);
                        end
                    end
                end
                CMD_POP_FRONT, CMD_POP_REAR, CMD_PEEK_FRONT, CMD_PEEK_REAR:
                begin
                    if (empty)
                    begin
                        rsp_next.status  = ST_EMPTY;
                        rsp_next.min_val = 1'b1;
                    end
                    else
                    begin
                        re               = 1'b1;
                        rsp_next.use_mem = 1'b1;
                        if (command == CMD_POP_FRONT || command == CMD_PEEK_FRONT)
                        begin
                            raddr = head_reg;
                        end
                        else
                        begin
                            raddr = tail_reg;
                        end
                        if (command == CMD_POP_FRONT || command == CMD_POP_REAR)
                        begin
                            count_next = count_reg - OCC_W'(1);
                            if (count_reg == OCC_W'(1))
                            begin
                                // last word gone: both ends back to entry 0
                                head_next = '0;
                                tail_next = '0;
                            end
                            else if (command == CMD_POP_FRONT)
                            begin
                                head_next = AW'(head_up);
                            end
                            else
                            begin
                                tail_next = AW'(tail_dn);
                            end
                        end
                    end
                end
                default:
                begin
                    rsp_next.status = ST_OK;
                end
            endcase
            rsp_next.occupancy = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            cap_reg   <= CAP_RESET;
            rsp_reg   <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            cap_reg   <= cap_next;
            rsp_reg   <= rsp_next;
        end
    end

    assign rsp         = rsp_reg;
    assign cap_reg_out = cap_reg;
endmodule
`default_nettype wire

/* sv/circular_deque.sv */
// Double-ended queue of words in a synchronous store; pointers live in flops.
// Timing: done and the result follow in the cycle after start is accepted; the word
//   comes from the store's registered read port in that cycle.
// Throughput: one word per cycle; busy is high only while the config port is
//   selected, and done cannot be held off by the receiver.
// Reset: pointers and count clear, capacity returns to 16; store not cleared.
`default_nettype none
module circular_deque #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // command side
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [cdq_pkg::CMD_W-1:0]         command,
    input  wire logic signed [DATA_WIDTH-1:0]      data,
    // result side
    output logic                                   done,
    output logic signed [DATA_WIDTH-1:0]           value,
    output logic      [cdq_pkg::ST_W-1:0]          status,
    output logic      [cdq_pkg::OCC_W-1:0]         occupancy,
    // config port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [2:0]                        paddr,
    input  wire logic [31:0]                       pwdata,
    output logic      [31:0]                       prdata,
    output logic                                   pready
);
    import cdq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam logic [DATA_WIDTH-1:0] INT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic             accept;
    logic             cfg_we;
    logic             reg_idx;
    logic             we, re;
    logic [AW-1:0]    waddr, raddr;
    logic [DATA_WIDTH-1:0] q;
    logic [OCC_W-1:0] cap_reg, cap_act;
    cdq_rsp_t         rsp;

    // config state and the deque share the pointers: hold off commands while
    // a bus transfer is underway
    assign busy    = psel;
    assign accept  = start && !busy;
    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign cfg_we  = psel && penable && pwrite && (reg_idx == REG_CAPACITY);

    always_comb
    begin
        unique case (reg_idx)
            REG_CAPACITY: prdata = {{(32-OCC_W){1'b0}}, cap_reg};
            default:      prdata = '0;
        endcase
    end

    cdq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .command     (command),
        .cfg_we      (cfg_we),
        .cfg_data    (pwdata[OCC_W-1:0]),
        .we          (we),
        .waddr       (waddr),
        .re          (re),
        .raddr       (raddr),
        .cap_reg_out (cap_reg),
        .cap_act     (cap_act),
        .rsp         (rsp)
    );

    cdq_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (data),
        .re    (re),
        .raddr (raddr),
        .q     (q)
    );

    // word: store output for a read hit, min int for empty, zero otherwise
    always_comb
    begin
        if (rsp.use_mem)
        begin
            value = q;
        end
        else if (rsp.min_val)
        begin
            value = INT_MIN;
        end
        else
        begin
            value = '0;
        end
    end

    assign done      = rsp.strobe;
    assign status    = rsp.status;
    assign occupancy = rsp.occupancy;

    // one result for every accepted command, in the cycle after it
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done == $past(accept))
        else $error("done does not track accepted command");

    // count never exceeds the active capacity
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> occupancy <= cap_act)
        else $error("occupancy above capacity");

    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_EMPTY |-> occupancy == '0 && value == INT_MIN)
        else $error("empty result with stored words");

    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_FULL |-> occupancy == cap_act && value == '0)
        else $error("dropped push while not full");

endmodule
`default_nettype wire
